>>> sv/i2ctt_pkg.sv
// shared types, widths and codes of the i2c telemetry register target
package i2ctt_pkg;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CHAN_W   = 2;
   localparam int unsigned ADC_W    = 12;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned ACC_W    = 17;
   localparam int unsigned MV_W     = 16;
   localparam int unsigned FS_W     = 16;
   localparam int unsigned VER_W    = 16;
   localparam int unsigned SLOTS    = 4;
   localparam int unsigned OFFSET_W = 5;

   localparam int unsigned DEF_SAMPLES_PER_AVERAGE = 32;
   localparam int unsigned DEF_NUM_CHANNELS        = 3;

   localparam logic [ADC_W-1:0] ADC_MAX = 12'd4095;
   localparam logic [ACC_W-1:0] ACC_MAX = 17'h1FFFF;

   // event codes carried in the kind field
   localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FINISH  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SAMPLE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PUBLISH = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] bus_byte;
      logic [CHAN_W-1:0] channel;
      logic [ADC_W-1:0]  adc_value;
      logic [TIME_W-1:0] timestamp_ms;
   } item_type;

   // published frame contents, slots past the channel count read zero
   typedef struct packed {
      logic                        published;
      logic [SLOTS-1:0][ADC_W-1:0] raw;
      logic [SLOTS-1:0][MV_W-1:0]  mv;
      logic [TIME_W-1:0]           time_ms;
   } frame_type;

endpackage

>>> sv/i2ctt_ifs.sv
// valid/ready channel interfaces for event words and read-data words
interface i2ctt_req_if;
   logic                             valid;
   logic                             ready;
   logic [i2ctt_pkg::KIND_W-1:0]     kind;
   logic [i2ctt_pkg::BYTE_W-1:0]     bus_byte;
   logic [i2ctt_pkg::CHAN_W-1:0]     channel;
   logic [i2ctt_pkg::ADC_W-1:0]      adc_value;
   logic [i2ctt_pkg::TIME_W-1:0]     timestamp_ms;

   modport source (output valid, kind, bus_byte, channel, adc_value, timestamp_ms,
                   input ready);
   modport sink   (input valid, kind, bus_byte, channel, adc_value, timestamp_ms,
                   output ready);
endinterface

interface i2ctt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [i2ctt_pkg::BYTE_W-1:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

>>> sv/i2ctt_bus.sv
// register pointer and frame byte selection for the bus side
module i2ctt_bus (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  i2ctt_pkg::item_type          item,
   input  i2ctt_pkg::frame_type         frame,
   input  logic [i2ctt_pkg::BYTE_W-1:0] frame_base,
   input  logic [i2ctt_pkg::VER_W-1:0]  version_word,
   input  logic [i2ctt_pkg::BYTE_W-1:0] status_value,
   output logic [i2ctt_pkg::BYTE_W-1:0] read_data
);

   logic [i2ctt_pkg::BYTE_W-1:0]   pointer_ff, pointer_in;
   logic                           captured_ff, captured_in;
   logic [i2ctt_pkg::BYTE_W-1:0]   diff;
   logic [i2ctt_pkg::OFFSET_W-1:0] offset;
   logic [i2ctt_pkg::OFFSET_W:0]   rel;
   logic [1:0]                     slot;
   logic [i2ctt_pkg::ADC_W-1:0]    raw_word;
   logic [i2ctt_pkg::MV_W-1:0]     mv_word;
   logic [i2ctt_pkg::BYTE_W-1:0]   sel_byte;

   // 5-bit value mod 3 from bit weights 1,2,1,2,1
   function automatic logic [1:0] mod3 (input logic [4:0] h);
      logic [2:0] s;
      s = 3'(h[0]) + 3'(h[2]) + 3'(h[4]) + {2'(h[1]) + 2'(h[3]), 1'b0};
      if (s >= 3'd6) begin
         s = s - 3'd6;
      end else if (s >= 3'd3) begin
         s = s - 3'd3;
      end
      return s[1:0];
   endfunction

   // offset into the 24-byte frame: 8*(hi mod 3) + lo
   assign diff   = pointer_ff - frame_base;
   assign offset = {mod3(diff[7:3]), diff[2:0]};

   always_comb begin
      sel_byte = '0;
      rel      = '0;
      slot     = '0;
      raw_word = '0;
      mv_word  = '0;
      if (!frame.published) begin
         sel_byte = '0;
      end else if (offset < 5'd2) begin
         sel_byte = offset[0] ? version_word[15:8] : version_word[7:0];
      end else if (offset < 5'd10) begin
         rel      = {1'b0, offset} - 6'd2;
         slot     = rel[2:1];
         raw_word = frame.raw[slot];
         sel_byte = offset[0] ? {4'b0, raw_word[11:8]} : raw_word[7:0];
      end else if (offset < 5'd18) begin
         rel      = {1'b0, offset} - 6'd10;
         slot     = rel[2:1];
         mv_word  = frame.mv[slot];
         sel_byte = offset[0] ? mv_word[15:8] : mv_word[7:0];
      end else if (offset < 5'd22) begin
         rel = {1'b0, offset} - 6'd18;
         case (rel[1:0])
            2'd0:    sel_byte = frame.time_ms[7:0];
            2'd1:    sel_byte = frame.time_ms[15:8];
            2'd2:    sel_byte = frame.time_ms[23:16];
            default: sel_byte = frame.time_ms[31:24];
         endcase
      end else if (offset == 5'd22) begin
         sel_byte = status_value;
      end
   end

   assign read_data = (pointer_ff < frame_base) ? '0 : sel_byte;

   always_comb begin
      pointer_in  = pointer_ff;
      captured_in = captured_ff;
      if (go) begin
         case (item.kind)
            i2ctt_pkg::KIND_WRITE: begin
               if (!captured_ff) begin
                  pointer_in  = item.bus_byte;
                  captured_in = 1'b1;
               end
            end
            i2ctt_pkg::KIND_READ:   pointer_in  = pointer_ff + 8'd1;
            i2ctt_pkg::KIND_FINISH: captured_in = 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff  <= '0;
         captured_ff <= 1'b0;
      end else begin
         pointer_ff  <= pointer_in;
         captured_ff <= captured_in;
      end
   end

endmodule

>>> sv/i2ctt_adc.sv
// sample accumulators and the three-step publish pipeline that fills the frame
module i2ctt_adc #(
   parameter int unsigned SAMPLES_PER_AVERAGE = i2ctt_pkg::DEF_SAMPLES_PER_AVERAGE,
   parameter int unsigned NUM_CHANNELS        = i2ctt_pkg::DEF_NUM_CHANNELS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  i2ctt_pkg::item_type        item,
   input  logic [i2ctt_pkg::FS_W-1:0] full_scale_mv,
   output i2ctt_pkg::frame_type       frame,
   output logic                       busy
);

   // divide by the sample count as multiply by a rounded-up reciprocal
   localparam int unsigned AVG_SHIFT = i2ctt_pkg::ACC_W + $clog2(SAMPLES_PER_AVERAGE);
   localparam int unsigned RECIP_W   = AVG_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** AVG_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
   localparam int unsigned PROD_W = i2ctt_pkg::ACC_W + RECIP_W;
   localparam int unsigned QUO_W  = PROD_W - AVG_SHIFT;
   localparam int unsigned MVP_W  = i2ctt_pkg::ADC_W + i2ctt_pkg::FS_W;

   typedef enum logic [1:0] {PUB_IDLE, PUB_AVG, PUB_MV} pub_state_type;

   pub_state_type                  state_ff;
   logic                           published_ff;
   logic [i2ctt_pkg::ACC_W-1:0]    acc_ff      [NUM_CHANNELS];
   logic [i2ctt_pkg::ACC_W-1:0]    acc_in      [NUM_CHANNELS];
   logic [i2ctt_pkg::ACC_W:0]      acc_sum     [NUM_CHANNELS];
   logic [PROD_W-1:0]              avg_prod_ff [NUM_CHANNELS];
   logic [i2ctt_pkg::ADC_W-1:0]    raw_ff      [NUM_CHANNELS];
   logic [i2ctt_pkg::ADC_W-1:0]    raw_in      [NUM_CHANNELS];
   logic [MVP_W-1:0]               mv_prod_ff  [NUM_CHANNELS];
   logic [i2ctt_pkg::MV_W-1:0]     mv_ff       [NUM_CHANNELS];
   logic [i2ctt_pkg::MV_W-1:0]     mv_in       [NUM_CHANNELS];
   logic [i2ctt_pkg::TIME_W-1:0]   time_ff;

   // floor(p / 4095) using 4096 = 4095 + 1 folded twice, then one correction
   function automatic logic [i2ctt_pkg::MV_W-1:0] div4095 (input logic [MVP_W-1:0] p);
      logic [16:0] y;
      logic [12:0] y2;
      logic [16:0] q;
      y  = 17'(p[MVP_W-1:12]) + 17'(p[11:0]);
      y2 = 13'(y[16:12]) + 13'(y[11:0]);
      q  = 17'(p[MVP_W-1:12]) + 17'(y[16:12]) + ((y2 >= 13'd4095) ? 17'd1 : 17'd0);
      return q[i2ctt_pkg::MV_W-1:0];
   endfunction

   function automatic logic [i2ctt_pkg::ADC_W-1:0] clamp_avg (input logic [PROD_W-1:0] p);
      logic [QUO_W-1:0] q;
      q = p[PROD_W-1:AVG_SHIFT];
      return (q > QUO_W'(i2ctt_pkg::ADC_MAX)) ? i2ctt_pkg::ADC_MAX : q[i2ctt_pkg::ADC_W-1:0];
   endfunction

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         acc_sum[c] = {1'b0, acc_ff[c]} + (i2ctt_pkg::ACC_W + 1)'(item.adc_value);
         acc_in[c]  = acc_sum[c][i2ctt_pkg::ACC_W] ? i2ctt_pkg::ACC_MAX
                                                   : acc_sum[c][i2ctt_pkg::ACC_W-1:0];
         raw_in[c]  = clamp_avg(avg_prod_ff[c]);
         mv_in[c]   = div4095(mv_prod_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PUB_IDLE;
         published_ff <= 1'b0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            acc_ff[c] <= '0;
         end
      end else begin
         unique case (state_ff)
            PUB_IDLE: begin
               if (go && item.kind == i2ctt_pkg::KIND_SAMPLE) begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     if (item.channel == i2ctt_pkg::CHAN_W'(c)) begin
                        acc_ff[c] <= acc_in[c];
                     end
                  end
               end
               if (go && item.kind == i2ctt_pkg::KIND_PUBLISH) begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     avg_prod_ff[c] <= PROD_W'(acc_ff[c]) * PROD_W'(RECIP);
                     acc_ff[c]      <= '0;
                  end
                  time_ff  <= item.timestamp_ms;
                  state_ff <= PUB_AVG;
               end
            end
            PUB_AVG: begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  raw_ff[c]     <= raw_in[c];
                  mv_prod_ff[c] <= MVP_W'(raw_in[c]) * MVP_W'(full_scale_mv);
               end
               state_ff <= PUB_MV;
            end
            PUB_MV: begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  mv_ff[c] <= mv_in[c];
               end
               published_ff <= 1'b1;
               state_ff     <= PUB_IDLE;
            end
            default: state_ff <= PUB_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != PUB_IDLE);

   always_comb begin
      frame           = '0;
      frame.published = published_ff;
      frame.time_ms   = time_ff;
      for (int s = 0; s < NUM_CHANNELS; s++) begin
         frame.raw[s] = raw_ff[s];
         frame.mv[s]  = mv_ff[s];
      end
   end

endmodule

>>> sv/i2c_telemetry_register_target.sv
// top level of the i2c telemetry register target
// Read-only register target that serves a 24-byte little-endian telemetry
// frame to an i2c bus controller, fed with bus events and adc samples as words
// on the req channel; each bus read request returns one data word on the rsp
// channel, every other kind returns nothing. Frame layout by offset from
// frame_base: version (2 bytes), three raw channel averages (2 bytes each, a
// fourth slot reads 0), the matching millivolt values, a 32-bit timestamp,
// the status byte and one reserved zero byte; before the first publish the
// whole frame reads 0. Throughput is one word per clock when nothing stalls:
// a word waits in the input register, its pointer, accumulator or read-data
// update is written when it goes ahead, so read data passes the input register
// and then the result register before it shows on rsp, and it waits in that
// output register, so the next word is taken while a result is still waiting.
// Two things hold the input back: a read whose result register is still full
// and not being taken, and a publish, which runs a three-step pipeline
// (average multiply, millivolt multiply, divide by 4095) and keeps the
// following word waiting until its last step is done. Averages divide the
// per-channel sums by SAMPLES_PER_AVERAGE; channels at or above NUM_CHANNELS
// are ignored. Configuration registers sit at byte addresses 0 (frame_base),
// 4 (full_scale_mv), 8 (version) and 12 (status_value); the user must write
// them only while the block is idle, which the block itself does not enforce.
module i2c_telemetry_register_target #(
   parameter int unsigned SAMPLES_PER_AVERAGE = i2ctt_pkg::DEF_SAMPLES_PER_AVERAGE,
   parameter int unsigned NUM_CHANNELS        = i2ctt_pkg::DEF_NUM_CHANNELS
) (
   input  logic               clock,
   input  logic               reset,
   i2ctt_req_if.sink          req,
   i2ctt_rsp_if.source        rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // register map index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_FRAME_BASE,
      REG_FULL_SCALE,
      REG_VERSION,
      REG_STATUS
   } reg_index_type;

   localparam logic [i2ctt_pkg::BYTE_W-1:0] RST_FRAME_BASE = 8'h10;
   localparam logic [i2ctt_pkg::FS_W-1:0]   RST_FULL_SCALE = 16'd3300;
   localparam logic [i2ctt_pkg::VER_W-1:0]  RST_VERSION    = 16'h0001;
   localparam logic [i2ctt_pkg::BYTE_W-1:0] RST_STATUS     = 8'h01;

   // config registers
   logic [i2ctt_pkg::BYTE_W-1:0] frame_base_ff;
   logic [i2ctt_pkg::FS_W-1:0]   full_scale_ff;
   logic [i2ctt_pkg::VER_W-1:0]  version_ff;
   logic [i2ctt_pkg::BYTE_W-1:0] status_ff;
   reg_index_type                reg_index;
   logic                         csr_write;

   // input register and result register
   logic                         item_valid_ff;
   i2ctt_pkg::item_type          item_ff;
   logic                         rsp_valid_ff;
   logic [i2ctt_pkg::BYTE_W-1:0] rsp_data_ff;

   logic                         go;
   logic                         item_is_read;
   logic                         pub_busy;
   logic                         req_take;
   logic [i2ctt_pkg::BYTE_W-1:0] read_data;
   i2ctt_pkg::frame_type         frame;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= RST_FRAME_BASE;
         full_scale_ff <= RST_FULL_SCALE;
         version_ff    <= RST_VERSION;
         status_ff     <= RST_STATUS;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_FRAME_BASE: frame_base_ff <= pwdata[7:0];
            REG_FULL_SCALE: full_scale_ff <= pwdata[15:0];
            REG_VERSION:    version_ff    <= pwdata[15:0];
            REG_STATUS:     status_ff     <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_FRAME_BASE: prdata = 32'(frame_base_ff);
         REG_FULL_SCALE: prdata = 32'(full_scale_ff);
         REG_VERSION:    prdata = 32'(version_ff);
         REG_STATUS:     prdata = 32'(status_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------- word flow ----------------
   // the buffered word goes ahead unless a publish is still running or a read
   // finds the result register full and not draining
   assign item_is_read = (item_ff.kind == i2ctt_pkg::KIND_READ);
   assign go           = item_valid_ff && !pub_busy
                         && (!item_is_read || !rsp_valid_ff || rsp.ready);
   assign req.ready    = !item_valid_ff || go;
   assign req_take     = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_take) begin
         item_valid_ff <= 1'b1;
      end else if (go) begin
         item_valid_ff <= 1'b0;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.kind         <= req.kind;
         item_ff.bus_byte     <= req.bus_byte;
         item_ff.channel      <= req.channel;
         item_ff.adc_value    <= req.adc_value;
         item_ff.timestamp_ms <= req.timestamp_ms;
      end
   end

   // result register, refilled in the same cycle it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && item_is_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && item_is_read) begin
         rsp_data_ff <= read_data;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;

   // ---------------- datapath ----------------
   i2ctt_bus u_bus (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .item         (item_ff),
      .frame        (frame),
      .frame_base   (frame_base_ff),
      .version_word (version_ff),
      .status_value (status_ff),
      .read_data    (read_data)
   );

   i2ctt_adc #(
      .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
      .NUM_CHANNELS        (NUM_CHANNELS)
   ) u_adc (
      .clock         (clock),
      .reset         (reset),
      .go            (go),
      .item          (item_ff),
      .full_scale_mv (full_scale_ff),
      .frame         (frame),
      .busy          (pub_busy)
   );

endmodule

>>> sv/i2ctt_checker.sv
// port-level checks on the telemetry target and their binding to it
module i2ctt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [i2ctt_pkg::BYTE_W-1:0] rsp_read_data,
   input logic                         psel,
   input logic                         penable,
   input logic                         pwrite,
   input logic [3:0]                   paddr,
   input logic [31:0]                  pwdata,
   input logic [31:0]                  prdata
);

   // a stalled read-data word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("read data word changed while stalled");

   // reset leaves no pending word and an open input
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state after reset not clean");

   // a register written reads back its masked value on the next cycle
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(psel && penable && pwrite) && paddr == $past(paddr)
      |-> prdata == ($past(pwdata)
                     & ((paddr[3:2] == 2'd0 || paddr[3:2] == 2'd3) ? 32'h0000_00FF
                                                                   : 32'h0000_FFFF)))
      else $error("register read-back mismatch");

endmodule

bind i2c_telemetry_register_target i2ctt_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_read_data (rsp.read_data),
   .psel          (psel),
   .penable       (penable),
   .pwrite        (pwrite),
   .paddr         (paddr),
   .pwdata        (pwdata),
   .prdata        (prdata)
);
